FILE: rtl/whb_pkg.sv
// ============================================================================
// whb_pkg
// Shared types and constants for the weighted histogram binner: command and
// status codes, sequencer states, register indexes and field widths.
// ============================================================================
`default_nettype none

package whb_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W  = 32;
    localparam int WEIGHT_W  = 16;
    localparam int INDEX_W   = 10;
    localparam int BIN_W     = 40;
    localparam int COUNT_W   = 11;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 2'd2;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST = 32'h0000_0000;
    localparam logic [SAMPLE_W-1:0] INV_WIDTH_RST = 32'h0001_0000;
    localparam logic [COUNT_W-1:0]  BIN_COUNT_RST = 11'd1024;

    // Saturation limits of a bin
    localparam logic [BIN_W-1:0] BIN_MAX = {1'b0, {(BIN_W-1){1'b1}}};
    localparam logic [BIN_W-1:0] BIN_MIN = {1'b1, {(BIN_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_FILL       = 2'd0,
        CMD_ADD        = 2'd1,
        CMD_READ       = 2'd2,
        CMD_READ_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BELOW  = 2'd1,
        ST_BEYOND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_LOOK,
        S_UPDATE,
        S_SEND
    } state_t;

    // Load strobes from the sequencer into the index unit
    typedef struct packed {
        logic diff_load;
        logic mul_load;
    } idx_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/weighted_histogram_binner.sv
// ============================================================================
// weighted_histogram_binner
// Steps from accept to result valid: a fill runs offset, multiply, RAM read,
// write back and send; add/read/read-clear skip the offset and multiply, and
// a request dropped as below range or out of use goes from the RAM read step
// straight to send. One request at a time: the next is accepted only once
// the send step is done. A result held by out_stall stretches only the send
// step of the request after it. Reset: control registers return to defaults,
// then a clearing pass zeroes all NUM_BINS bins with in_stall held high.
// ============================================================================
`default_nettype none

module weighted_histogram_binner #(
    parameter int NUM_BINS = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_write,
    input  wire logic [whb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [whb_pkg::CFG_W-1:0]           cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          command,
    input  wire logic signed [whb_pkg::SAMPLE_W-1:0] sample,
    input  wire logic signed [whb_pkg::WEIGHT_W-1:0] weight,
    input  wire logic [whb_pkg::INDEX_W-1:0]         bin_index,
    input  wire logic signed [whb_pkg::BIN_W-1:0]    add_value,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [1:0]                               status,
    output logic [whb_pkg::INDEX_W-1:0]              result_index,
    output logic signed [whb_pkg::BIN_W-1:0]         bin_value
);

    localparam int AW = $clog2(NUM_BINS);

    whb_pkg::state_t                 state_reg;
    whb_pkg::state_t                 state_next;

    // Configuration
    logic [whb_pkg::SAMPLE_W-1:0]    range_low_reg;
    logic [whb_pkg::SAMPLE_W-1:0]    inv_width_reg;
    logic [whb_pkg::COUNT_W-1:0]     bin_count_reg;

    // Captured request
    whb_pkg::cmd_t                   cmd_reg;
    logic [whb_pkg::SAMPLE_W-1:0]    sample_reg;
    logic [whb_pkg::WEIGHT_W-1:0]    weight_reg;
    logic [whb_pkg::INDEX_W-1:0]     bin_index_reg;
    logic [whb_pkg::BIN_W-1:0]       add_value_reg;

    // Working result
    logic [AW-1:0]                   clr_addr_reg;
    logic [AW-1:0]                   addr_reg;
    whb_pkg::status_t                res_status_reg;
    logic [whb_pkg::INDEX_W-1:0]     res_index_reg;
    logic [whb_pkg::BIN_W-1:0]       res_value_reg;

    // Output register
    logic                            out_valid_reg;
    logic [1:0]                      out_status_reg;
    logic [whb_pkg::INDEX_W-1:0]     out_index_reg;
    logic [whb_pkg::BIN_W-1:0]       out_value_reg;

    whb_pkg::idx_ctrl_t              idx_ctrl;
    logic                            below;
    logic [whb_pkg::SAMPLE_W-1:0]    bin_number;

    logic                            in_accept;
    logic                            out_take;
    logic                            out_load;
    logic [whb_pkg::SAMPLE_W-1:0]    look_idx;
    logic [whb_pkg::SAMPLE_W-1:0]    bins_used;
    logic                            look_ok;
    whb_pkg::status_t                look_status;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [whb_pkg::BIN_W-1:0]       ram_wdata;
    logic                            ram_re;
    logic [whb_pkg::BIN_W-1:0]       ram_rdata;

    logic [whb_pkg::BIN_W:0]         addend;
    logic [whb_pkg::BIN_W:0]         sum;
    logic [whb_pkg::BIN_W-1:0]       sat_sum;
    logic [whb_pkg::BIN_W-1:0]       upd_value;
    logic                            upd_write;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    // ------------------------------------------------------------------
    // Index unit
    // ------------------------------------------------------------------
    whb_bin_index u_bin_index (
        .clk               (clk),
        .ctrl              (idx_ctrl),
        .sample            (sample_reg),
        .range_low         (range_low_reg),
        .inverse_bin_width (inv_width_reg),
        .below             (below),
        .bin_number        (bin_number)
    );

    // ------------------------------------------------------------------
    // Bin store
    // ------------------------------------------------------------------
    whb_ram #(
        .WIDTH (whb_pkg::BIN_W),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (look_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Range check of the addressed bin
    // ------------------------------------------------------------------
    always_comb
    begin
        look_idx  = (cmd_reg == whb_pkg::CMD_FILL) ? bin_number
                                                   : whb_pkg::SAMPLE_W'(bin_index_reg);
        bins_used = (whb_pkg::SAMPLE_W'(bin_count_reg) > whb_pkg::SAMPLE_W'(NUM_BINS))
                  ? whb_pkg::SAMPLE_W'(NUM_BINS) : whb_pkg::SAMPLE_W'(bin_count_reg);
        if ((cmd_reg == whb_pkg::CMD_FILL) && below)
        begin
            look_status = whb_pkg::ST_BELOW;
        end
        else if (look_idx >= bins_used)
        begin
            look_status = whb_pkg::ST_BEYOND;
        end
        else
        begin
            look_status = whb_pkg::ST_OK;
        end
        look_ok = (look_status == whb_pkg::ST_OK);
    end

    // ------------------------------------------------------------------
    // Saturating update of the bin read back from the RAM
    // ------------------------------------------------------------------
    always_comb
    begin
        if (cmd_reg == whb_pkg::CMD_FILL)
        begin
            addend = {{(whb_pkg::BIN_W + 1 - whb_pkg::WEIGHT_W){weight_reg[whb_pkg::WEIGHT_W-1]}},
                      weight_reg};
        end
        else
        begin
            addend = {add_value_reg[whb_pkg::BIN_W-1], add_value_reg};
        end
        sum = {ram_rdata[whb_pkg::BIN_W-1], ram_rdata} + addend;
        if (sum[whb_pkg::BIN_W] != sum[whb_pkg::BIN_W-1])
        begin
            sat_sum = sum[whb_pkg::BIN_W] ? whb_pkg::BIN_MIN : whb_pkg::BIN_MAX;
        end
        else
        begin
            sat_sum = sum[whb_pkg::BIN_W-1:0];
        end
        case (cmd_reg)
            whb_pkg::CMD_FILL,
            whb_pkg::CMD_ADD:
            begin
                upd_value = sat_sum;
                upd_write = 1'b1;
            end
            whb_pkg::CMD_READ_CLEAR:
            begin
                upd_value = ram_rdata;
                upd_write = 1'b1;
            end
            default:
            begin
                upd_value = ram_rdata;
                upd_write = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state, strobes and RAM controls
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        in_stall           = 1'b1;
        idx_ctrl.diff_load = 1'b0;
        idx_ctrl.mul_load  = 1'b0;
        ram_we             = 1'b0;
        ram_waddr          = addr_reg;
        ram_wdata          = '0;
        ram_re             = 1'b0;
        out_load           = 1'b0;
        case (state_reg)
            whb_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == AW'(NUM_BINS - 1))
                begin
                    state_next = whb_pkg::S_IDLE;
                end
            end
            whb_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = (whb_pkg::cmd_t'(command) == whb_pkg::CMD_FILL)
                               ? whb_pkg::S_DIFF : whb_pkg::S_LOOK;
                end
            end
            whb_pkg::S_DIFF:
            begin
                idx_ctrl.diff_load = 1'b1;
                state_next         = whb_pkg::S_MUL;
            end
            whb_pkg::S_MUL:
            begin
                idx_ctrl.mul_load = 1'b1;
                state_next        = whb_pkg::S_LOOK;
            end
            whb_pkg::S_LOOK:
            begin
                ram_re     = look_ok;
                state_next = look_ok ? whb_pkg::S_UPDATE : whb_pkg::S_SEND;
            end
            whb_pkg::S_UPDATE:
            begin
                ram_we     = upd_write;
                ram_wdata  = (cmd_reg == whb_pkg::CMD_READ_CLEAR) ? '0 : sat_sum;
                state_next = whb_pkg::S_SEND;
            end
            whb_pkg::S_SEND:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = whb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = whb_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= whb_pkg::S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            range_low_reg <= whb_pkg::RANGE_LOW_RST;
            inv_width_reg <= whb_pkg::INV_WIDTH_RST;
            bin_count_reg <= whb_pkg::BIN_COUNT_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == whb_pkg::S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            // Hold result until taken, replace when a new one lands
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            // Register writes; an index past the list is dropped
            if (cfg_write)
            begin
                case (cfg_index)
                    whb_pkg::REG_RANGE_LOW: range_low_reg <= cfg_data;
                    whb_pkg::REG_INV_WIDTH: inv_width_reg <= cfg_data;
                    whb_pkg::REG_BIN_COUNT: bin_count_reg <= cfg_data[whb_pkg::COUNT_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // Capture request
        if (in_accept)
        begin
            cmd_reg       <= whb_pkg::cmd_t'(command);
            sample_reg    <= sample;
            weight_reg    <= weight;
            bin_index_reg <= bin_index;
            add_value_reg <= add_value;
        end
        // Latch bin address and status; zero the fields of a dropped request
        if (state_reg == whb_pkg::S_LOOK)
        begin
            addr_reg       <= look_idx[AW-1:0];
            res_status_reg <= look_status;
            res_index_reg  <= look_ok ? look_idx[whb_pkg::INDEX_W-1:0] : '0;
            res_value_reg  <= '0;
        end
        if (state_reg == whb_pkg::S_UPDATE)
        begin
            res_value_reg <= upd_value;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_index = out_index_reg;
    assign bin_value    = out_value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall
    ) else $error("request accepted while previous one still in work");

    a_result_from_send: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == whb_pkg::S_SEND)
    ) else $error("result appeared outside the send step");

    a_dropped_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status != whb_pkg::ST_OK)) |-> (result_index == '0 && bin_value == '0)
    ) else $error("dropped request carries a nonzero bin or value");

    a_ram_write_window: assert property (
        @(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == whb_pkg::S_CLEAR || state_reg == whb_pkg::S_UPDATE)
    ) else $error("bin store written outside clear or update");

endmodule

`default_nettype wire

FILE: rtl/whb_ram.sv
// ============================================================================
// whb_ram
// Generic single-clock RAM with one write port and one read port. Read data
// is registered and appears in the cycle after the read strobe.
// ============================================================================
`default_nettype none

module whb_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/whb_bin_index.sv
// ============================================================================
// whb_bin_index
// Bin number of a fill sample in two registered steps: the exact 33-bit
// offset from the lower range edge, then its product with the reciprocal
// bin width, keeping the integer part of the Q32.32 result.
// ============================================================================
`default_nettype none

module whb_bin_index (
    input  wire logic                              clk,
    input  wire whb_pkg::idx_ctrl_t                ctrl,
    input  wire logic [whb_pkg::SAMPLE_W-1:0]      sample,
    input  wire logic [whb_pkg::SAMPLE_W-1:0]      range_low,
    input  wire logic [whb_pkg::SAMPLE_W-1:0]      inverse_bin_width,
    output logic                                   below,
    output logic [whb_pkg::SAMPLE_W-1:0]           bin_number
);

    logic [whb_pkg::SAMPLE_W:0]       diff_reg;
    logic [whb_pkg::SAMPLE_W:0]       diff_next;
    logic [2*whb_pkg::SAMPLE_W-1:0]   product;
    logic [whb_pkg::SAMPLE_W-1:0]     bin_reg;

    // Sign-extend both operands so the offset is exact
    assign diff_next = {sample[whb_pkg::SAMPLE_W-1], sample}
                     - {range_low[whb_pkg::SAMPLE_W-1], range_low};

    // Offset is non-negative here, so its low 32 bits are the whole magnitude
    assign product = {{whb_pkg::SAMPLE_W{1'b0}}, diff_reg[whb_pkg::SAMPLE_W-1:0]}
                   * {{whb_pkg::SAMPLE_W{1'b0}}, inverse_bin_width};

    // Capture offset, then integer part of the scaled offset
    always_ff @(posedge clk)
    begin
        if (ctrl.diff_load)
        begin
            diff_reg <= diff_next;
        end
        if (ctrl.mul_load)
        begin
            bin_reg <= product[2*whb_pkg::SAMPLE_W-1:whb_pkg::SAMPLE_W];
        end
    end

    assign below      = diff_reg[whb_pkg::SAMPLE_W];
    assign bin_number = bin_reg;

endmodule

`default_nettype wire

FILE: tb/tb_weighted_histogram_binner.sv
// ============================================================================
// tb_weighted_histogram_binner
// Self-checking regression for the fixed-width histogram binner. A queue of
// requests feeds a clocked driver; every accepted request runs through a
// bit-accurate predictor of the bin store, and a clocked monitor compares
// each result in order. Several register settings are covered, including
// the range and reciprocal extremes, a single bin, no bins and an oversized
// bin count. Both handshakes idle and stall at random.
// ============================================================================

module tb_weighted_histogram_binner;

    localparam int NUM_BINS  = 1024;
    localparam int DRAIN_CYC = 10;
    localparam int LIMIT_CYC = 200000;
    localparam logic [whb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        whb_pkg::cmd_t                       cmd;
        logic signed [whb_pkg::SAMPLE_W-1:0] sample;
        logic signed [whb_pkg::WEIGHT_W-1:0] weight;
        logic [whb_pkg::INDEX_W-1:0]         index;
        logic signed [whb_pkg::BIN_W-1:0]    add_value;
    } hist_req_t;

    typedef struct {
        whb_pkg::status_t                 status;
        logic [whb_pkg::INDEX_W-1:0]      index;
        logic signed [whb_pkg::BIN_W-1:0] value;
    } bin_result_t;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                cfg_write    = 1'b0;
    logic [whb_pkg::CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [whb_pkg::CFG_W-1:0]           cfg_data     = '0;
    logic                                in_valid     = 1'b0;
    logic                                in_stall;
    logic [1:0]                          command      = '0;
    logic signed [whb_pkg::SAMPLE_W-1:0] sample       = '0;
    logic signed [whb_pkg::WEIGHT_W-1:0] weight       = '0;
    logic [whb_pkg::INDEX_W-1:0]         bin_index    = '0;
    logic signed [whb_pkg::BIN_W-1:0]    add_value    = '0;
    logic                                out_valid;
    logic                                out_stall    = 1'b0;
    logic [1:0]                          status;
    logic [whb_pkg::INDEX_W-1:0]         result_index;
    logic signed [whb_pkg::BIN_W-1:0]    bin_value;

    // Predictor copy of the registers and the bin store
    logic signed [whb_pkg::SAMPLE_W-1:0] cur_range_low = whb_pkg::RANGE_LOW_RST;
    logic [whb_pkg::SAMPLE_W-1:0]        cur_inv_width = whb_pkg::INV_WIDTH_RST;
    logic [whb_pkg::COUNT_W-1:0]         cur_bin_count = whb_pkg::BIN_COUNT_RST;
    logic signed [whb_pkg::BIN_W-1:0]    bin_model [NUM_BINS];

    hist_req_t   req_q[$];
    bin_result_t pending_results[$];
    hist_req_t   cur_req;
    bin_result_t head_result;
    logic [whb_pkg::SAMPLE_W-1:0] sample_window = '0;
    int queued_cnt   = 0;
    int accepted_cnt = 0;
    int mismatch_cnt = 0;
    int idle_pct     = 29;

    weighted_histogram_binner #(
        .NUM_BINS(NUM_BINS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .sample       (sample),
        .weight       (weight),
        .bin_index    (bin_index),
        .add_value    (add_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_index (result_index),
        .bin_value    (bin_value)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int bins_in_use();
        return (cur_bin_count > NUM_BINS) ? NUM_BINS : int'(cur_bin_count);
    endfunction

    // Clamp a 41-bit sum to the signed 40-bit bin range
    function automatic logic signed [whb_pkg::BIN_W-1:0] clamp_bin(
        input logic signed [whb_pkg::BIN_W:0] total);
        if (total[whb_pkg::BIN_W] != total[whb_pkg::BIN_W-1])
            return total[whb_pkg::BIN_W] ? whb_pkg::BIN_MIN : whb_pkg::BIN_MAX;
        return total[whb_pkg::BIN_W-1:0];
    endfunction

    // Apply one request to the bin store and queue the result it must give
    function automatic void predict_histogram(input hist_req_t r);
        bin_result_t                       res;
        logic signed [whb_pkg::SAMPLE_W:0] offset;
        logic [2*whb_pkg::SAMPLE_W-1:0]    scaled;
        logic [whb_pkg::SAMPLE_W-1:0]      slot;
        logic signed [whb_pkg::BIN_W:0]    total;
        int                                used;
        used       = bins_in_use();
        res.status = whb_pkg::ST_OK;
        res.index  = '0;
        res.value  = '0;
        if (r.cmd == whb_pkg::CMD_FILL)
        begin
            offset = {r.sample[whb_pkg::SAMPLE_W-1], r.sample}
                   - {cur_range_low[whb_pkg::SAMPLE_W-1], cur_range_low};
            if (offset[whb_pkg::SAMPLE_W])
            begin
                res.status = whb_pkg::ST_BELOW;
            end
            else
            begin
                scaled = offset[whb_pkg::SAMPLE_W-1:0] * cur_inv_width;
                slot   = scaled[2*whb_pkg::SAMPLE_W-1:whb_pkg::SAMPLE_W];
                if (slot >= used)
                begin
                    res.status = whb_pkg::ST_BEYOND;
                end
                else
                begin
                    total           = bin_model[slot];
                    total           = total + r.weight;
                    bin_model[slot] = clamp_bin(total);
                    res.index       = slot[whb_pkg::INDEX_W-1:0];
                    res.value       = bin_model[slot];
                end
            end
        end
        else if (r.index >= used)
        begin
            res.status = whb_pkg::ST_BEYOND;
        end
        else
        begin
            res.index = r.index;
            res.value = bin_model[r.index];
            if (r.cmd == whb_pkg::CMD_ADD)
            begin
                total              = bin_model[r.index];
                total              = total + r.add_value;
                bin_model[r.index] = clamp_bin(total);
                res.value          = bin_model[r.index];
            end
            else if (r.cmd == whb_pkg::CMD_READ_CLEAR)
            begin
                bin_model[r.index] = '0;
            end
        end
        pending_results.push_back(res);
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function automatic hist_req_t directed_req(input whb_pkg::cmd_t c,
                                               input logic [whb_pkg::SAMPLE_W-1:0] s,
                                               input logic [whb_pkg::WEIGHT_W-1:0] w,
                                               input logic [whb_pkg::INDEX_W-1:0] i,
                                               input logic [whb_pkg::BIN_W-1:0] a);
        hist_req_t r;
        r.cmd       = c;
        r.sample    = s;
        r.weight    = w;
        r.index     = i;
        r.add_value = a;
        return r;
    endfunction

    // Random request: mostly samples inside the window above range_low and
    // bins near the ones in use, some samples below it, plus whole-field noise
    function automatic hist_req_t make_request();
        hist_req_t r;
        int        pick;
        int        used;
        used = bins_in_use();
        pick = $urandom_range(99);
        if (pick < 55)
            r.cmd = whb_pkg::CMD_FILL;
        else if (pick < 70)
            r.cmd = whb_pkg::CMD_ADD;
        else if (pick < 85)
            r.cmd = whb_pkg::CMD_READ;
        else
            r.cmd = whb_pkg::CMD_READ_CLEAR;

        pick = $urandom_range(99);
        if (pick < 75)
            r.sample = cur_range_low + whb_pkg::SAMPLE_W'($urandom_range(sample_window));
        else if (pick < 88)
            r.sample = cur_range_low - whb_pkg::SAMPLE_W'($urandom_range(262144, 1));
        else
            r.sample = $urandom;

        r.weight = ($urandom_range(99) < 20) ? whb_pkg::WEIGHT_W'(1)
                                             : whb_pkg::WEIGHT_W'($urandom);

        if ($urandom_range(99) < 80)
            r.index = $urandom_range((used + 2 > 1023) ? 1023 : used + 2);
        else
            r.index = whb_pkg::INDEX_W'($urandom);

        pick = $urandom_range(99);
        if (pick < 60)
            r.add_value = $signed(24'($urandom));
        else if (pick < 90)
            r.add_value = whb_pkg::BIN_W'({$urandom, $urandom});
        else
            r.add_value = $urandom_range(1) ? whb_pkg::BIN_MAX : whb_pkg::BIN_MIN;
        return r;
    endfunction

    task automatic queue_request(input hist_req_t r);
        req_q.push_back(r);
        queued_cnt++;
    endtask

    // Write one register; only called while nothing is in flight
    task automatic write_reg(input logic [whb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [whb_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            whb_pkg::REG_RANGE_LOW: cur_range_low = data;
            whb_pkg::REG_INV_WIDTH: cur_inv_width = data;
            whb_pkg::REG_BIN_COUNT: cur_bin_count = data[whb_pkg::COUNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Hold until every queued request is taken and every result is back
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic run_phase(input logic [whb_pkg::SAMPLE_W-1:0] lo,
                             input logic [whb_pkg::SAMPLE_W-1:0] inv,
                             input logic [whb_pkg::COUNT_W-1:0] count,
                             input logic [whb_pkg::SAMPLE_W-1:0] span, input int items);
        write_reg(whb_pkg::REG_RANGE_LOW, lo);
        write_reg(whb_pkg::REG_INV_WIDTH, inv);
        write_reg(whb_pkg::REG_BIN_COUNT, {21'($urandom), count});
        sample_window = span;
        for (int n = 0; n < items; n++)
            queue_request(make_request());
        wait_drained();
    endtask

    // Driver: record the accepted request, then present the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_histogram(cur_req);
                accepted_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    cur_req   = req_q.pop_front();
                    in_valid  <= 1'b1;
                    command   <= cur_req.cmd;
                    sample    <= cur_req.sample;
                    weight    <= cur_req.weight;
                    bin_index <= cur_req.index;
                    add_value <= cur_req.add_value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    note_failure($sformatf("unexpected result: status %0d index %0d value %0d",
                                           status, result_index, bin_value));
                end
                else
                begin
                    head_result = pending_results.pop_front();
                    if (status !== head_result.status || result_index !== head_result.index
                        || bin_value !== head_result.value)
                        note_failure($sformatf(
                            "expected status %0d index %0d value %0d, got %0d %0d %0d",
                            head_result.status, head_result.index, head_result.value,
                            status, result_index, bin_value));
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    initial
    begin
        #(LIMIT_CYC * 8);
        $display("weighted_histogram_binner regression: fail");
        $finish;
    end

    initial
    begin
        for (int b = 0; b < NUM_BINS; b++)
            bin_model[b] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests at the reset settings: one bin per unit sample
        queue_request(directed_req(whb_pkg::CMD_READ, '0, '0, 10'd0, '0));
        queue_request(directed_req(whb_pkg::CMD_READ, '0, '0, 10'd1023, '0));
        queue_request(directed_req(whb_pkg::CMD_FILL, 32'h0000_0000, 16'd1, '0, '0));
        queue_request(directed_req(whb_pkg::CMD_FILL, 32'h7FFF_FFFF, 16'h7FFF, '0, '0));
        queue_request(directed_req(whb_pkg::CMD_FILL, 32'h8000_0000, 16'h8000, '0, '0));
        queue_request(directed_req(whb_pkg::CMD_FILL, 32'hFFFF_FFFF, 16'd1, '0, '0));
        queue_request(directed_req(whb_pkg::CMD_FILL, 32'h03FF_FFFF, 16'h8000, '0, '0));
        queue_request(directed_req(whb_pkg::CMD_FILL, 32'h0400_0000, 16'd1, '0, '0));
        // Drive bins 5 and 6 into saturation from both sides
        queue_request(directed_req(whb_pkg::CMD_ADD, '0, '0, 10'd5, whb_pkg::BIN_MAX));
        queue_request(directed_req(whb_pkg::CMD_FILL, 32'h0005_8000, 16'h7FFF, '0, '0));
        queue_request(directed_req(whb_pkg::CMD_ADD, '0, '0, 10'd6, whb_pkg::BIN_MIN));
        queue_request(directed_req(whb_pkg::CMD_ADD, '0, '0, 10'd6, '1));
        queue_request(directed_req(whb_pkg::CMD_FILL, 32'h0006_0000, 16'h8000, '0, '0));
        queue_request(directed_req(whb_pkg::CMD_READ_CLEAR, '0, '0, 10'd5, '0));
        queue_request(directed_req(whb_pkg::CMD_READ, '0, '0, 10'd5, '0));
        queue_request(directed_req(whb_pkg::CMD_ADD, '0, '0, 10'd1023, 40'h55_5555_5555));
        queue_request(directed_req(whb_pkg::CMD_ADD, '0, '0, 10'd1023, 40'hAA_AAAA_AAAA));
        queue_request(directed_req(whb_pkg::CMD_READ_CLEAR, '0, '0, 10'd1023, '0));
        queue_request(directed_req(whb_pkg::CMD_READ_CLEAR, '0, '0, 10'd6, '0));
        queue_request(directed_req(whb_pkg::CMD_FILL, 32'h0000_FFFF, 16'h5A5A, '0, '0));
        wait_drained();

        // Range from -100.0, bins 4.0 wide, 64 bins
        run_phase(32'hFF9C_0000, 32'h0000_4000, 11'd64, 32'd270 << 16, 300);

        // Lowest range edge, largest reciprocal, oversized count; no idling
        idle_pct = 0;
        run_phase(32'h8000_0000, 32'hFFFF_FFFF, 11'd2047, 32'd1100, 300);
        idle_pct = 29;

        // Highest range edge, zero reciprocal, a single bin
        run_phase(32'h7FFF_FFFF, 32'h0000_0000, 11'd1, 32'd0, 80);

        // No bins in use; also poke the unused register index
        write_reg(REG_UNUSED, $urandom);
        run_phase(32'h0000_0000, 32'h0001_0000, 11'd0, 32'd40 << 16, 40);

        // Range from 16.0, bins 0.5 wide, all bins
        run_phase(32'h0010_0000, 32'h0002_0000, 11'd1024, 32'd520 << 16, 580);

        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("weighted_histogram_binner regression: pass");
        else
            $display("weighted_histogram_binner regression: fail");
        $finish;
    end

endmodule
